>>> rtl/core/mac_pkg.sv
// ============================================================================
// mac_pkg
// Shared types and constants for the memory admission control block.
// ============================================================================
`default_nettype none

package mac_pkg;

    localparam int DATA_W     = 64;
    localparam int FRAC_W     = 17;
    localparam int FRAC_SHIFT = 16;
    localparam int LIMIT_W    = 32;
    localparam int INST_ID_W  = 6;
    localparam int REQ_ID_W   = 8;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // limit * fraction, full width
    localparam int PROD_W = DATA_W + FRAC_W;

    localparam logic [DATA_W-1:0] DATA_MAX = '1;

    // register reset values
    localparam logic [FRAC_W-1:0]  HIGH_FRACTION_RST       = 17'd58982;
    localparam logic [FRAC_W-1:0]  LOW_FRACTION_RST        = 17'd52429;
    localparam logic [LIMIT_W-1:0] SMALL_MESSAGE_LIMIT_RST = 32'd65536;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_FRACTION       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_FRACTION        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_MESSAGE_LIMIT = 2'd2;

    // item kinds
    localparam logic KIND_ADMIT   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_SMALL    = 3'd0,
        ST_TRACKED  = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_HIGH     = 3'd3,
        ST_AVERAGE  = 3'd4,
        ST_RELEASED = 3'd5,
        ST_UNKNOWN  = 3'd6
    } status_t;

endpackage

`default_nettype wire

>>> rtl/core/mac_if.sv
// ============================================================================
// mac_if
// Channel interfaces: item input, result output, register write.
// ============================================================================
`default_nettype none

interface mac_in_if;
    import mac_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [INST_ID_W-1:0] instance_id;
    logic [REQ_ID_W-1:0]  request_id;
    logic [DATA_W-1:0]    msg_size;
    logic [DATA_W-1:0]    current_usage;
    logic [DATA_W-1:0]    usage_limit;

    modport source (output valid, kind, instance_id, request_id, msg_size,
                    current_usage, usage_limit, input ready);
    modport sink   (input valid, kind, instance_id, request_id, msg_size,
                    current_usage, usage_limit, output ready);
endinterface

interface mac_out_if;
    import mac_pkg::*;

    logic                valid;
    logic                ready;
    logic                allowed;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   estimate_total_out;

    modport source (output valid, allowed, status, estimate_total_out, input ready);
    modport sink   (input valid, allowed, status, estimate_total_out, output ready);
endinterface

interface mac_cfg_if;
    import mac_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/memory_admission_control.sv
// ============================================================================
// memory_admission_control
// Admission control for messages against a memory limit, with per-instance
// and per-request charge tables held in on-chip memories.
// ============================================================================
//
// Usage:
//   item   : one word per admit or release request (valid/ready).
//   result : one word per item: allowed, status, estimate after the item.
//   cfg    : register writes (index, data), always ready; write only while
//            the block is idle.
// Operation:
//   After reset the block sweeps both charge tables to zero, one entry per
//   cycle, across max(INSTANCE_SLOTS, REQUEST_SLOTS) entries; item.ready is
//   low during the sweep.
//   An accepted item passes the table read, the threshold/average multiply
//   stage and the decide/write-back stage; a new item is taken only after
//   the current one has committed and its result word has been registered.
//   The result register lets the next item be accepted while a finished
//   word waits; if the receiver stalls, the next item stops in the decide
//   stage without touching state until the result register frees up.
// ============================================================================
`default_nettype none

module memory_admission_control #(
    parameter int INSTANCE_SLOTS = 64,
    parameter int REQUEST_SLOTS  = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    mac_in_if.sink    item,
    mac_out_if.source result,
    mac_cfg_if.sink   cfg
);
    import mac_pkg::*;

    // table address widths
    localparam int IW = (INSTANCE_SLOTS > 1) ? $clog2(INSTANCE_SLOTS) : 1;
    localparam int RW = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;
    // active count 0..INSTANCE_SLOTS, divisor 1..INSTANCE_SLOTS+1
    localparam int AW = $clog2(INSTANCE_SLOTS + 1);
    localparam int DW = $clog2(INSTANCE_SLOTS + 2);
    localparam int AVG_W = DATA_W + DW;
    // clearing sweep
    localparam int CLR_DEPTH = (INSTANCE_SLOTS > REQUEST_SLOTS) ? INSTANCE_SLOTS
                                                                 : REQUEST_SLOTS;
    localparam int CLR_W = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
    localparam int INST_MAP_N = 2 ** INST_ID_W;
    localparam int REQ_MAP_N  = 2 ** REQ_ID_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_MUL   = 4'b0100,
        S_DEC   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // ------------------------------------------------------------------
    // ID to slot: id modulo table depth, folded into constant tables
    // ------------------------------------------------------------------
    logic [IW-1:0] inst_map [INST_MAP_N];
    logic [RW-1:0] req_map  [REQ_MAP_N];

    for (genvar g = 0; g < INST_MAP_N; g++) begin : g_inst_map
        assign inst_map[g] = IW'(g % INSTANCE_SLOTS);
    end
    for (genvar g = 0; g < REQ_MAP_N; g++) begin : g_req_map
        assign req_map[g] = RW'(g % REQUEST_SLOTS);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [CLR_W-1:0]   clr_cnt_reg;
    logic [FRAC_W-1:0]  hi_frac_reg;
    logic [FRAC_W-1:0]  lo_frac_reg;
    logic [LIMIT_W-1:0] small_lim_reg;
    logic [DATA_W-1:0]  est_reg, est_next;
    logic [AW-1:0]      active_reg, active_next;

    // captured item
    logic               kind_reg;
    logic [IW-1:0]      inst_idx_reg;
    logic [RW-1:0]      req_idx_reg;
    logic [DATA_W-1:0]  size_reg;
    logic [DATA_W-1:0]  cur_reg;
    logic [DATA_W-1:0]  limit_reg;

    // table read data
    logic [DATA_W-1:0]  inst_rd_reg;
    logic [DATA_W-1:0]  req_rd_reg;

    // multiply stage
    logic [PROD_W-1:0]  high_prod_reg;
    logic [PROD_W-1:0]  low_prod_reg;
    logic [AVG_W-1:0]   avg_prod_reg;
    logic [DATA_W:0]    sum_reg;

    // result register
    logic               out_valid_reg;
    logic               out_allowed_reg;
    status_t            out_status_reg;
    logic [DATA_W-1:0]  out_est_reg;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic accept;
    logic commit;
    logic clr_last;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && (state_reg == S_IDLE);
    assign commit     = (state_reg == S_DEC) && (!out_valid_reg || result.ready);
    assign clr_last   = (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1));

    assign cfg.ready = 1'b1;

    assign result.valid              = out_valid_reg;
    assign result.allowed            = out_allowed_reg;
    assign result.status             = out_status_reg;
    assign result.estimate_total_out = out_est_reg;

    // ------------------------------------------------------------------
    // Charge tables: one write port, one registered read port each
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] inst_mem [INSTANCE_SLOTS];
    logic [DATA_W-1:0] req_mem  [REQUEST_SLOTS];

    logic              inst_we, req_we;
    logic [IW-1:0]     inst_wa;
    logic [RW-1:0]     req_wa;
    logic [DATA_W-1:0] inst_wd, req_wd;

    always_ff @(posedge clk)
    begin
        if (inst_we)
        begin
            inst_mem[inst_wa] <= inst_wd;
        end
        if (accept)
        begin
            inst_rd_reg <= inst_mem[inst_map[item.instance_id]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_we)
        begin
            req_mem[req_wa] <= req_wd;
        end
        if (accept)
        begin
            req_rd_reg <= req_mem[req_map[item.request_id]];
        end
    end

    // ------------------------------------------------------------------
    // Item capture and multiply stage (payload, no reset)
    // ------------------------------------------------------------------
    logic [DW-1:0] divisor;

    assign divisor = DW'(active_reg) + DW'(1);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= item.kind;
            inst_idx_reg <= inst_map[item.instance_id];
            req_idx_reg  <= req_map[item.request_id];
            size_reg     <= item.msg_size;
            cur_reg      <= item.current_usage;
            limit_reg    <= item.usage_limit;
        end
        if (state_reg == S_MUL)
        begin
            // thresholds: floor(limit * frac / 2^16)
            high_prod_reg <= PROD_W'(limit_reg) * PROD_W'(hi_frac_reg);
            low_prod_reg  <= PROD_W'(limit_reg) * PROD_W'(lo_frac_reg);
            // mine <= est / (n+1)  <=>  mine * (n+1) <= est
            avg_prod_reg  <= AVG_W'(inst_rd_reg) * AVG_W'(divisor);
            sum_reg       <= {1'b0, cur_reg} + {1'b0, size_reg};
        end
    end

    // ------------------------------------------------------------------
    // Decide stage
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] high_thr, low_thr;
    logic              over_high, is_small, low_ok, track;
    logic [DATA_W:0]   est_add, inst_add;
    logic [DATA_W-1:0] est_sat, inst_sat;
    logic              dec_allowed;
    status_t           dec_status;

    assign high_thr = high_prod_reg[PROD_W-1] ? DATA_MAX
                                              : high_prod_reg[PROD_W-2:FRAC_SHIFT];
    assign low_thr  = low_prod_reg[PROD_W-1] ? DATA_MAX
                                             : low_prod_reg[PROD_W-2:FRAC_SHIFT];

    assign over_high = (sum_reg[DATA_W-1:0] > high_thr);
    assign is_small  = (size_reg <= DATA_W'(small_lim_reg));
    assign low_ok    = (cur_reg <= low_thr) && (est_reg <= low_thr);
    assign track     = low_ok || (inst_rd_reg == '0)
                    || (avg_prod_reg <= AVG_W'(est_reg));

    assign est_add  = {1'b0, est_reg} + {1'b0, size_reg};
    assign inst_add = {1'b0, inst_rd_reg} + {1'b0, size_reg};
    assign est_sat  = est_add[DATA_W] ? DATA_MAX : est_add[DATA_W-1:0];
    assign inst_sat = inst_add[DATA_W] ? DATA_MAX : inst_add[DATA_W-1:0];

    always_comb
    begin
        est_next    = est_reg;
        active_next = active_reg;
        inst_we     = 1'b0;
        inst_wa     = inst_idx_reg;
        inst_wd     = '0;
        req_we      = 1'b0;
        req_wa      = req_idx_reg;
        req_wd      = '0;
        dec_allowed = 1'b0;
        dec_status  = ST_UNKNOWN;

        if (kind_reg == KIND_RELEASE)
        begin
            if (req_rd_reg == '0)
            begin
                // empty request slot: nothing changes
                dec_status = ST_UNKNOWN;
            end
            else
            begin
                dec_status = ST_RELEASED;
                est_next   = (est_reg < req_rd_reg) ? '0 : est_reg - req_rd_reg;
                if (inst_rd_reg <= req_rd_reg)
                begin
                    inst_wd = '0;
                    if ((inst_rd_reg != '0) && (active_reg != '0))
                    begin
                        active_next = active_reg - AW'(1);
                    end
                end
                else
                begin
                    inst_wd = inst_rd_reg - req_rd_reg;
                end
                inst_we = commit;
                req_we  = commit;
            end
        end
        else
        begin
            priority if (sum_reg[DATA_W])
            begin
                dec_status = ST_OVERFLOW;
            end
            else if (over_high)
            begin
                dec_status = ST_HIGH;
            end
            else if (is_small)
            begin
                dec_allowed = 1'b1;
                dec_status  = ST_SMALL;
            end
            else if (!track)
            begin
                dec_status = ST_AVERAGE;
            end
            else
            begin
                dec_allowed = 1'b1;
                dec_status  = ST_TRACKED;
                est_next    = est_sat;
                if (inst_rd_reg == '0)
                begin
                    active_next = active_reg + AW'(1);
                end
                inst_wd = inst_sat;
                inst_we = commit;
                req_wd  = size_reg;
                req_we  = commit;
            end
        end

        // clearing sweep after reset
        if (state_reg == S_CLEAR)
        begin
            inst_we = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(INSTANCE_SLOTS));
            inst_wa = clr_cnt_reg[IW-1:0];
            inst_wd = '0;
            req_we  = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(REQUEST_SLOTS));
            req_wa  = clr_cnt_reg[RW-1:0];
            req_wd  = '0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            est_reg       <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_CLEAR) && !clr_last)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            if (commit)
            begin
                est_reg       <= est_next;
                active_reg    <= active_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_allowed_reg <= dec_allowed;
            out_status_reg  <= dec_status;
            out_est_reg     <= est_next;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_frac_reg   <= HIGH_FRACTION_RST;
            lo_frac_reg   <= LOW_FRACTION_RST;
            small_lim_reg <= SMALL_MESSAGE_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_HIGH_FRACTION:
                begin
                    hi_frac_reg <= cfg.data[FRAC_W-1:0];
                end
                CFG_LOW_FRACTION:
                begin
                    lo_frac_reg <= cfg.data[FRAC_W-1:0];
                end
                CFG_SMALL_MESSAGE_LIMIT:
                begin
                    small_lim_reg <= cfg.data[LIMIT_W-1:0];
                end
                default:
                begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= AW'(INSTANCE_SLOTS))
        else $error("active instance count above table depth");

    a_mul_to_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |=> (state_reg == S_DEC))
        else $error("multiply stage not followed by decide stage");

    a_release_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (kind_reg == KIND_RELEASE)) |=> (est_reg <= $past(est_reg)))
        else $error("estimate grew on a release");

    a_table_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        (inst_we || req_we) |-> ((state_reg == S_CLEAR) || commit))
        else $error("table written outside sweep or commit");

endmodule

`default_nettype wire
